FILE: sv/vbpg_pkg.sv
// Package for the vibration burst pattern generator.
// Holds the result record, burst codes and the per-mode segment table.
// No dependencies.
package vbpg_pkg;

	localparam int MODE_W   = 4;
	localparam int DUTY_W   = 6;
	localparam int TICK_W   = 13;
	localparam int PHASE_W  = 8;
	localparam int PERIOD_W = 16;
	localparam int BURST_W  = 4;
	localparam int HWD_W    = 8;
	localparam int SEGP_W   = 8;
	localparam int GAP_W    = 11;

	localparam logic [MODE_W-1:0] MODE_SOFT_FREE = 4'd1;
	localparam logic [MODE_W-1:0] MODE_PAT2      = 4'd2;
	localparam logic [MODE_W-1:0] MODE_PAT3      = 4'd3;
	localparam logic [MODE_W-1:0] MODE_PAT4      = 4'd4;
	localparam logic [MODE_W-1:0] MODE_PAT5      = 4'd5;
	localparam logic [MODE_W-1:0] MODE_PAT6      = 4'd6;
	localparam logic [MODE_W-1:0] MODE_PAT7      = 4'd7;
	localparam logic [MODE_W-1:0] MODE_SOFT_LAST = 4'd8;
	localparam logic [MODE_W-1:0] MODE_HW_SLOW   = 4'd9;
	localparam logic [MODE_W-1:0] MODE_HW_FAST   = 4'd10;

	localparam logic [TICK_W-1:0] HW_IVAL_SLOW = 13'd3906;
	localparam logic [TICK_W-1:0] HW_IVAL_FAST = 13'd781;
	localparam logic [HWD_W-1:0]  HW_DUTY_LOW  = 8'd41;
	localparam logic [HWD_W-1:0]  HW_DUTY_HIGH = 8'd148;

	typedef enum logic [1:0] {
		BURST_KEEP,
		BURST_INC,
		BURST_CLR
	} burst_op_t;

	typedef struct packed {
		logic [SEGP_W-1:0] periods;
		logic [GAP_W-1:0]  gap;
		burst_op_t         op;
	} seg_cfg_t;

	typedef struct packed {
		logic             drive;
		logic [HWD_W-1:0] hw_duty;
		logic             hw_enable;
	} result_t;

	function automatic seg_cfg_t seg_lookup(input logic [MODE_W-1:0] mode,
			input logic [BURST_W-1:0] burst);
		seg_cfg_t c;
		c = '{periods: 8'd26, gap: 11'd1431, op: BURST_KEEP};
		case (mode)
			MODE_PAT2: c = '{periods: 8'd17, gap: 11'd833, op: BURST_KEEP};
			MODE_PAT3: c = '{periods: 8'd8, gap: 11'd387, op: BURST_KEEP};
			MODE_PAT4: begin
				if (burst < 4'd9) c = '{periods: 8'd7, gap: 11'd387, op: BURST_INC};
				else c = '{periods: 8'd87, gap: 11'd387, op: BURST_CLR};
			end
			MODE_PAT5: c = '{periods: 8'd5, gap: 11'd178, op: BURST_KEEP};
			MODE_PAT6: begin
				if (burst < 4'd6) c = '{periods: 8'd4, gap: 11'd1193, op: BURST_INC};
				else if (burst < 4'd13) c = '{periods: 8'd25, gap: 11'd1432, op: BURST_INC};
				else c = '{periods: 8'd206, gap: 11'd1193, op: BURST_CLR};
			end
			MODE_PAT7: begin
				if (burst < 4'd1) c = '{periods: 8'd4, gap: 11'd477, op: BURST_INC};
				else if (burst < 4'd8) c = '{periods: 8'd5, gap: 11'd477, op: BURST_INC};
				else c = '{periods: 8'd183, gap: 11'd483, op: BURST_CLR};
			end
			default: c = '{periods: 8'd26, gap: 11'd1431, op: BURST_KEEP};
		endcase
		return c;
	endfunction

endpackage

FILE: sv/vibration_burst_pattern_generator.sv
// Top level of the vibration burst pattern generator.
// Stream ports around vbpg_step plus the result register.
// Depends on vbpg_pkg and vbpg_step.

// One input transfer is one timer tick and yields one result transfer. Each tick
// is handled combinationally by the step logic and lands in one output register,
// so a tick can be accepted every clock while the output side keeps up; the result
// is valid in the cycle after the input transfer. s_tready is high whenever the
// output register is empty or being emptied in the same cycle.
module vibration_burst_pattern_generator #(
	parameter int PWM_PERIOD = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [3:0] mode, [9:4] duty, [15:10] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] drive, [8:1] hw_duty, [9] hw_enable, [15:10] zero
);
	import vbpg_pkg::*;

	logic    accept;
	result_t res;
	result_t res_q;
	logic    valid_q;

	assign s_tready = !valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	vbpg_step #(
		.PWM_PERIOD(PWM_PERIOD)
	) u_step (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (accept),
		.mode  (s_tdata[MODE_W-1:0]),
		.duty  (s_tdata[MODE_W+DUTY_W-1:MODE_W]),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'd0, res_q.hw_enable, res_q.hw_duty, res_q.drive};

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("transfer accepted but no result");

	a_hw_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> !m_tdata[0])
		else $error("soft drive active in hardware mode");

	a_hw_duty_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[8:1] == HW_DUTY_LOW || m_tdata[8:1] == HW_DUTY_HIGH)
		else $error("hardware mode with unset duty");

endmodule

FILE: sv/vbpg_step.sv
// Per-tick pattern state and next-state logic.
// Holds the tick, phase, period and burst counters, last mode and held levels.
// Depends on vbpg_pkg.
module vbpg_step #(
	parameter int PWM_PERIOD = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [vbpg_pkg::MODE_W-1:0]   mode,
	input  logic [vbpg_pkg::DUTY_W-1:0]   duty,
	output vbpg_pkg::result_t             result
);
	import vbpg_pkg::*;

	localparam logic [PHASE_W-1:0] PERIOD_C = PHASE_W'(PWM_PERIOD);

	logic [MODE_W-1:0]   last_mode_q, last_mode_d;
	logic [TICK_W-1:0]   tick_q, tick_d;
	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic [PERIOD_W-1:0] period_q, period_d;
	logic [BURST_W-1:0]  burst_q, burst_d;
	logic [HWD_W-1:0]    duty_hold_q, duty_hold_d;
	logic                drive_q, drive_d;

	logic                is_soft, is_hw;
	logic [TICK_W-1:0]   ival;
	seg_cfg_t            cfg;
	logic [PHASE_W-1:0]  duty_x;

	assign is_soft = (mode >= MODE_SOFT_FREE) && (mode <= MODE_SOFT_LAST);
	assign is_hw   = (mode == MODE_HW_SLOW) || (mode == MODE_HW_FAST);
	assign ival    = (mode == MODE_HW_SLOW) ? HW_IVAL_SLOW : HW_IVAL_FAST;
	assign duty_x  = PHASE_W'(duty);

	always_comb begin
		last_mode_d = last_mode_q;
		tick_d      = tick_q;
		phase_d     = phase_q;
		period_d    = period_q;
		burst_d     = burst_q;
		duty_hold_d = duty_hold_q;
		drive_d     = drive_q;
		cfg         = seg_lookup(mode, burst_q);

		if (is_soft) begin
			if (mode != last_mode_q) begin
				last_mode_d = mode;
				tick_d      = '0;
				phase_d     = '0;
				period_d    = '0;
			end
			if (mode == MODE_SOFT_FREE || period_d < PERIOD_W'(cfg.periods)) begin
				if (phase_d < PERIOD_C) begin
					drive_d = (duty_x >= PERIOD_C) ? 1'b1 : (phase_d < duty_x);
				end else begin
					period_d = period_d + 1'b1;
					phase_d  = '0;
				end
				if (mode != MODE_SOFT_FREE) tick_d = '0;
			end else if (tick_d < TICK_W'(cfg.gap)) begin
				drive_d = 1'b0;
			end else begin
				tick_d   = '0;
				phase_d  = '0;
				period_d = '0;
				case (cfg.op)
					BURST_INC: burst_d = burst_q + 1'b1;
					BURST_CLR: burst_d = '0;
					default:   burst_d = burst_q;
				endcase
			end
		end else if (is_hw) begin
			if (mode != last_mode_q) begin
				last_mode_d = mode;
				tick_d      = '0;
			end
			if (tick_d < ival) duty_hold_d = HW_DUTY_LOW;
			else if (tick_d < {ival[TICK_W-2:0], 1'b0}) duty_hold_d = HW_DUTY_HIGH;
			else tick_d = '0;
		end

		result.drive     = is_soft & drive_d;
		result.hw_duty   = duty_hold_d;
		result.hw_enable = is_hw;

		tick_d  = tick_d + 1'b1;
		phase_d = phase_d + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mode_q <= '0;
			tick_q      <= '0;
			phase_q     <= '0;
			period_q    <= '0;
			burst_q     <= '0;
			duty_hold_q <= '0;
			drive_q     <= 1'b0;
		end else if (step) begin
			last_mode_q <= last_mode_d;
			tick_q      <= tick_d;
			phase_q     <= phase_d;
			period_q    <= period_d;
			burst_q     <= burst_d;
			duty_hold_q <= duty_hold_d;
			drive_q     <= drive_d;
		end
	end

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(tick_q) && $stable(burst_q) && $stable(last_mode_q))
		else $error("state moved without a transfer");

	a_hold_levels: assert property (@(posedge clk) disable iff (!arst_n)
		duty_hold_q == '0 || duty_hold_q == HW_DUTY_LOW || duty_hold_q == HW_DUTY_HIGH)
		else $error("hardware duty out of set");

	a_hw_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_hw && mode != last_mode_q |=> duty_hold_q == HW_DUTY_LOW)
		else $error("hardware mode entry did not start low");

endmodule
